// ----- rtl/swmm_pkg.sv -----
package swmm_pkg;

	localparam int WINDOW_DEPTH = 64;
	localparam int SAMPLE_W     = 16;
	localparam int VAL_W        = 15;
	localparam int COUNT_OUT_W  = 7;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W        = VAL_W + ADDR_W;
	localparam int DIV_STEP_W   = $clog2(SUM_W);
	localparam int QDEPTH       = 2;
	localparam int QADDR_W      = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic             taken;
		logic [VAL_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- rtl/swmm_front.sv -----
module swmm_front import swmm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                q_vld,
	input  logic                q_take,
	output item_t               q_item
);

	item_t              fifo_q [QDEPTH];
	logic [QADDR_W-1:0] wptr_q;
	logic [QADDR_W-1:0] rptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push;
	logic               do_pop;
	item_t              new_item;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign q_vld   = (cnt_q != '0);
	assign q_item  = fifo_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_vld;

	// classify: a set sign bit marks a sample to discard
	always_comb begin
		new_item.taken = !sample[SAMPLE_W-1];
		new_item.value = sample[VAL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == QADDR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QADDR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/swmm_div.sv -----
module swmm_div import swmm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [CNT_W-1:0]      rem_q;
	logic [SUM_W-1:0]      quo_q;
	logic [CNT_W-1:0]      den_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W:0]        rem_sh;
	logic                  fits;

	// one quotient bit per cycle, restoring
	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign fits   = (rem_sh >= {1'b0, den_q});

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(rem_sh - {1'b0, den_q}) : rem_sh[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/swmm_back.sv -----
module swmm_back import swmm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_vld,
	output logic                   q_take,
	input  item_t                  q_item,
	output logic                   empty,
	input  logic                   pop,
	output logic [VAL_W-1:0]       window_max,
	output logic [VAL_W-1:0]       window_min,
	output logic [VAL_W-1:0]       window_mean,
	output logic [COUNT_OUT_W-1:0] window_count,
	output logic                   sample_taken
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_SWAP,
		ST_SCAN,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t            state_q;
	item_t             item_q;
	logic [VAL_W-1:0]  mem [WINDOW_DEPTH];
	logic [VAL_W-1:0]  rd_data_s1;
	logic              rd_zero_s1;
	logic              scan_vld_s1;
	logic              zero0_q;
	logic [ADDR_W-1:0] old_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic [ADDR_W-1:0] scan_addr_q;
	logic [CNT_W-1:0]  issued_q;
	logic [VAL_W-1:0]  hi_q;
	logic [VAL_W-1:0]  lo_q;
	logic [VAL_W-1:0]  mean_q;
	logic              div_start_q;
	logic              res_vld_q;
	logic [VAL_W-1:0]  res_max_q;
	logic [VAL_W-1:0]  res_min_q;
	logic [VAL_W-1:0]  res_mean_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic              res_taken_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [ADDR_W:0]   app_sum;
	logic [ADDR_W-1:0] app_addr;
	logic [ADDR_W-1:0] old_next;
	logic [ADDR_W-1:0] scan_next;
	logic              win_full;
	logic [VAL_W-1:0]  rd_val;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign win_full  = (cnt_q == CNT_W'(WINDOW_DEPTH));
	assign app_sum   = {1'b0, old_q} + (ADDR_W + 1)'(cnt_q);
	assign app_addr  = (app_sum >= (ADDR_W + 1)'(WINDOW_DEPTH)) ?
		ADDR_W'(app_sum - (ADDR_W + 1)'(WINDOW_DEPTH)) : app_sum[ADDR_W-1:0];
	assign old_next  = (old_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : old_q + 1'b1;
	assign scan_next = (scan_addr_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : scan_addr_q + 1'b1;
	// entry zero reads as zero until first written
	assign rd_val    = rd_zero_s1 ? '0 : rd_data_s1;
	assign q_take    = (state_q == ST_IDLE) && q_vld;

	assign div_req.start    = div_start_q;
	assign div_req.dividend = sum_q;
	assign div_req.divisor  = cnt_q;

	swmm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = app_addr;
		mem_re    = 1'b0;
		mem_raddr = scan_addr_q;
		case (state_q)
			ST_UPD: begin
				if (item_q.taken) begin
					if (!win_full) begin
						mem_we = 1'b1;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = old_q;
					end
				end
			end
			ST_SWAP: begin
				mem_we    = 1'b1;
				mem_waddr = old_q;
			end
			ST_SCAN: begin
				mem_re = (issued_q != cnt_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= item_q.value;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_raddr];
			rd_zero_s1 <= zero0_q && (mem_raddr == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			zero0_q     <= 1'b1;
			old_q       <= '0;
			cnt_q       <= CNT_W'(1);
			sum_q       <= '0;
			scan_addr_q <= '0;
			issued_q    <= '0;
			hi_q        <= '0;
			lo_q        <= '1;
			mean_q      <= '0;
			scan_vld_s1 <= 1'b0;
			div_start_q <= 1'b0;
			res_vld_q   <= 1'b0;
			res_max_q   <= '0;
			res_min_q   <= '0;
			res_mean_q  <= '0;
			res_cnt_q   <= '0;
			res_taken_q <= 1'b0;
		end else begin
			if (mem_we && (mem_waddr == '0)) begin
				zero0_q <= 1'b0;
			end
			scan_vld_s1 <= (state_q == ST_SCAN) && mem_re;
			// start the divide once the last scanned entry is folded in
			div_start_q <= (state_q == ST_SCAN) && (issued_q == cnt_q) && !scan_vld_s1;
			if ((state_q == ST_DONE) && (!res_vld_q || pop)) begin
				res_vld_q <= 1'b1;
			end else if (pop) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_vld) begin
						item_q  <= q_item;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					scan_addr_q <= old_q;
					issued_q    <= '0;
					hi_q        <= '0;
					lo_q        <= '1;
					if (!item_q.taken) begin
						state_q <= ST_SCAN;
					end else if (!win_full) begin
						cnt_q   <= cnt_q + 1'b1;
						sum_q   <= sum_q + SUM_W'(item_q.value);
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_SWAP;
					end
				end
				ST_SWAP: begin
					// drop the oldest beat, append the new one in its slot
					sum_q       <= sum_q - SUM_W'(rd_val) + SUM_W'(item_q.value);
					old_q       <= old_next;
					scan_addr_q <= old_next;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_vld_s1) begin
						if (rd_val > hi_q) begin
							hi_q <= rd_val;
						end
						if (rd_val < lo_q) begin
							lo_q <= rd_val;
						end
					end
					if (issued_q != cnt_q) begin
						issued_q    <= issued_q + 1'b1;
						scan_addr_q <= scan_next;
					end else if (!scan_vld_s1) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						mean_q  <= div_rsp.quotient[VAL_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the result slot frees up
					if (!res_vld_q || pop) begin
						res_max_q   <= hi_q;
						res_min_q   <= lo_q;
						res_mean_q  <= mean_q;
						res_cnt_q   <= cnt_q;
						res_taken_q <= item_q.taken;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty        = !res_vld_q;
	assign window_max   = res_max_q;
	assign window_min   = res_min_q;
	assign window_mean  = res_mean_q;
	assign window_count = COUNT_OUT_W'(res_cnt_q);
	assign sample_taken = res_taken_q;

endmodule

// ----- rtl/sliding_window_min_max_mean_top.sv -----
// Sliding window min / max / mean over non-negative Q8.8 samples.
//
// Input side is a queue: drive sample and push; a beat is taken on a clock
// edge with push high and full low. A sample with its sign bit set is not
// added to the window but still yields a result with sample_taken low.
// Result side is a queue too: while empty is low the oldest result sits on
// window_max / window_min / window_mean / window_count / sample_taken, and
// it leaves on an edge with pop high.
// A two-entry input queue feeds the window engine, which handles one beat
// at a time: it dequeues the beat, updates the window store (ST_UPD, plus
// ST_SWAP when the window is full), scans the store (one read port, one
// entry per cycle), runs the bit-serial mean divide, then posts the
// result.
// Reset leaves the window holding one zero sample (count 1, sum 0); no
// clearing pass is needed. If pop stays low the finished result is held,
// the engine still takes the next beat and stops before posting it, and
// full rises once the input queue fills.
module sliding_window_min_max_mean_top import swmm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_W-1:0]    sample,
	output logic                   empty,
	input  logic                   pop,
	output logic [VAL_W-1:0]       window_max,
	output logic [VAL_W-1:0]       window_min,
	output logic [VAL_W-1:0]       window_mean,
	output logic [COUNT_OUT_W-1:0] window_count,
	output logic                   sample_taken
);

	logic  q_vld;
	logic  q_take;
	item_t q_item;

	swmm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.sample (sample),
		.q_vld  (q_vld),
		.q_take (q_take),
		.q_item (q_item)
	);

	swmm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_vld        (q_vld),
		.q_take       (q_take),
		.q_item       (q_item),
		.empty        (empty),
		.pop          (pop),
		.window_max   (window_max),
		.window_min   (window_min),
		.window_mean  (window_mean),
		.window_count (window_count),
		.sample_taken (sample_taken)
	);

endmodule
